[hdl/h2t_pkg.sv]
// Shared types, constants and helpers of the HTML to plain text filter.
package h2t_pkg;

  localparam int ENTITY_SPAN  = 10;
  localparam int TAG_KEEP     = 4;
  localparam int NAME_CNT_MAX = 7;
  localparam int REPLAY_DEPTH = ENTITY_SPAN + 2;
  localparam int FIFO_DEPTH   = 4;
  localparam int WORD_W       = 10;
  localparam int SPAN_W       = $clog2(ENTITY_SPAN + 1);
  localparam int WIN_AW       = $clog2(ENTITY_SPAN);
  localparam int REP_W        = $clog2(REPLAY_DEPTH + 1);
  localparam int TAG_AW       = $clog2(TAG_KEEP);
  localparam int HR_STEPS     = 20;
  localparam int HR_W         = $clog2(HR_STEPS);

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_QMARK = 8'h3F;

  // Token between front and back: one text byte, or the document end mark.
  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       mark;
  } tok_t;

  typedef struct packed {
    logic [7:0] data;
    logic       none;
    logic       last;
  } res_t;

  typedef enum logic [1:0] {F_IDLE, F_HR, F_MARK} front_state_t;
  typedef enum logic [1:0] {B_RUN, B_PUSH, B_FLUSH, B_FIN} back_state_t;
  typedef enum logic [2:0] {
    P_NM0, P_OFF, P_HASH, P_WS, P_SIGN, P_ZERO, P_DIG, P_STOP
  } parse_t;

  typedef struct packed {
    parse_t     st;
    logic       hexb;
    logic       neg;
    logic [7:0] val;
  } parse_reg_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

[hdl/html_to_plain_text_filter.sv]
// Top level of the HTML to plain text filter.
//
// Input channel: push/full queue interface carrying in_byte and in_final. An
// item is taken on a clock edge with push high and full low. Output channel:
// empty/pop queue interface; the oldest result item (out_byte, out_none,
// out_final) is shown while empty is low and leaves on an edge with pop high.
//
// The front strips markup, collapses whitespace and adds the newlines and
// the hr rule; it takes one item per cycle while the middle queue has room,
// except while it sends the rule after an hr tag and the end mark after the
// last byte of a document. A four-entry queue decouples it from the back,
// which decodes entities at one byte per cycle while the output queue has
// room, and replays unmatched entity text, pausing in B_PUSH to put the
// window back byte by byte. A result passes the middle queue and the output
// queue before it shows on the output; the last result of a document shows
// only after the end mark, once the back has flushed any open entity bytes
// in B_FLUSH and sent that result from B_FIN.
//
// At the end of a document the last result carries out_final; if the last
// item gave no text one result with out_none is sent instead. Reset (rst,
// synchronous) empties both queues and returns all parsing state to idle.
// When the receiver stalls the output queue fills, the back holds, the middle
// queue fills and full rises; no item is dropped.
module html_to_plain_text_filter
  import h2t_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_final,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_none,
  output logic       out_final
);

  tok_t              tok_in, tok_out;
  logic              tok_wr;
  logic              mid_full, mid_empty, mid_rd;
  logic [WORD_W-1:0] mid_rdata;
  res_t              res_in, res_out;
  logic              res_wr, res_full;
  logic [WORD_W-1:0] res_rdata;

  // Strip markup and classify bytes.
  h2t_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .in_byte  (in_byte),
    .in_final (in_final),
    .full     (full),
    .tok_wr   (tok_wr),
    .tok      (tok_in),
    .mid_full (mid_full)
  );

  // Decouple the stripper from the entity decoder.
  h2t_fifo u_mid (
    .clk   (clk),
    .rst   (rst),
    .wr    (tok_wr),
    .wdata (tok_in),
    .full  (mid_full),
    .rd    (mid_rd),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign tok_out = tok_t'(mid_rdata);

  // Decode entities and mark document end.
  h2t_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok_out),
    .mid_empty (mid_empty),
    .mid_rd    (mid_rd),
    .out_wr    (res_wr),
    .res       (res_in),
    .out_full  (res_full)
  );

  // Hold results until the receiver pops them.
  h2t_fifo u_out (
    .clk   (clk),
    .rst   (rst),
    .wr    (res_wr),
    .wdata (res_in),
    .full  (res_full),
    .rd    (pop && !empty),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign res_out   = res_t'(res_rdata);
  assign out_byte  = res_out.data;
  assign out_none  = res_out.none;
  assign out_final = res_out.last;

endmodule

[hdl/h2t_fifo.sv]
// Small register queue carrying one packed word per item.
module h2t_fifo
  import h2t_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  logic [WORD_W-1:0] wdata,
  output logic              full,
  input  logic              rd,
  output logic [WORD_W-1:0] rdata,
  output logic              empty
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  logic [WORD_W-1:0] mem [FIFO_DEPTH];
  logic [AW-1:0]     wptr;
  logic [AW-1:0]     rptr;
  logic [CW-1:0]     count;

  assign full  = (count == CW'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == AW'(FIFO_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == AW'(FIFO_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr |-> !full)
    else $error("write into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd |-> !empty)
    else $error("read from empty queue");

endmodule

[hdl/h2t_front.sv]
// Markup stripper: drops tags, collapses whitespace, emits newlines and the hr rule.
module h2t_front
  import h2t_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [7:0] in_byte,
  input  logic       in_final,
  output logic       full,
  output logic       tok_wr,
  output tok_t       tok,
  input  logic       mid_full
);

  front_state_t st, st_next;
  logic         inmk, inmk_next;
  logic         spc, spc_next;
  logic         tstart, tstart_next;
  logic         endnl, endnl_next;
  logic [7:0]   tagb [TAG_KEEP];
  logic [2:0]   tcnt, tcnt_next;
  logic         tclosed, tclosed_next;
  logic [HR_W-1:0] hk, hk_next;
  logic [1:0]   ph, ph_next;
  logic         fin_s, fin_s_next;
  logic         tag_wr;
  logic [7:0]   lc;
  logic         is_head, is_hr, nl_ok;

  always_comb begin
    lc = (in_byte >= "A" && in_byte <= "Z") ? in_byte + 8'd32 : in_byte;
    is_head = ((tcnt == 3'd2) && tagb[0] == "b" && tagb[1] == "r") ||
              ((tcnt == 3'd1) && tagb[0] == "p") ||
              ((tcnt == 3'd3) && tagb[0] == "d" && tagb[1] == "i" && tagb[2] == "v") ||
              ((tcnt == 3'd2) && tagb[0] == "l" && tagb[1] == "i") ||
              ((tcnt == 3'd2) && tagb[0] == "u" && tagb[1] == "l") ||
              ((tcnt == 3'd2) && tagb[0] == "o" && tagb[1] == "l") ||
              ((tcnt == 3'd2) && tagb[0] == "h" && tagb[1] >= "1" && tagb[1] <= "6");
    is_hr = (tcnt == 3'd2) && tagb[0] == "h" && tagb[1] == "r";
    nl_ok = tstart && !endnl;
  end

  always_comb begin
    st_next      = st;
    inmk_next    = inmk;
    spc_next     = spc;
    tstart_next  = tstart;
    endnl_next   = endnl;
    tcnt_next    = tcnt;
    tclosed_next = tclosed;
    hk_next      = hk;
    ph_next      = ph;
    fin_s_next   = fin_s;
    tag_wr       = 1'b0;
    tok_wr       = 1'b0;
    tok          = '{data: 8'h00, fin: 1'b0, mark: 1'b0};
    full         = (st != F_IDLE) || mid_full;
    case (st)
      F_IDLE: begin
        if (push && !mid_full) begin
          tok.fin    = in_final;
          fin_s_next = in_final;
          if (in_final) begin
            st_next = F_MARK;
          end
          if (inmk) begin
            if (in_byte == CH_GT) begin
              inmk_next    = 1'b0;
              tcnt_next    = '0;
              tclosed_next = 1'b0;
              if (is_head) begin
                spc_next = 1'b0;
                if (nl_ok) begin
                  tok_wr      = 1'b1;
                  tok.data    = CH_NL;
                  endnl_next  = 1'b1;
                end
              end else if (is_hr) begin
                st_next = F_HR;
                hk_next = '0;
                ph_next = '0;
              end
            end else if (!tclosed) begin
              if (in_byte == CH_SPACE || in_byte == CH_TAB || in_byte == CH_SLASH) begin
                tclosed_next = 1'b1;
              end else begin
                tag_wr = (tcnt < 3'(TAG_KEEP));
                if (tcnt < 3'(NAME_CNT_MAX)) begin
                  tcnt_next = tcnt + 1'b1;
                end
              end
            end
          end else if (in_byte == CH_LT) begin
            inmk_next    = 1'b1;
            tcnt_next    = '0;
            tclosed_next = 1'b0;
          end else if (is_ws(in_byte)) begin
            if (!spc) begin
              tok_wr      = 1'b1;
              tok.data    = CH_SPACE;
              spc_next    = 1'b1;
              tstart_next = 1'b1;
              endnl_next  = 1'b0;
            end
          end else begin
            tok_wr      = 1'b1;
            tok.data    = in_byte;
            spc_next    = 1'b0;
            tstart_next = 1'b1;
            endnl_next  = 1'b0;
          end
        end
      end
      F_HR: begin
        tok.fin = fin_s;
        if (!mid_full) begin
          hk_next = hk + 1'b1;
          if (hk == '0 || hk == HR_W'(HR_STEPS - 1)) begin
            spc_next = 1'b0;
            if (nl_ok) begin
              tok_wr     = 1'b1;
              tok.data   = CH_NL;
              endnl_next = 1'b1;
            end
            if (hk != '0) begin
              st_next = fin_s ? F_MARK : F_IDLE;
            end
          end else begin
            tok_wr      = 1'b1;
            tstart_next = 1'b1;
            endnl_next  = 1'b0;
            ph_next     = (ph == 2'd2) ? 2'd0 : ph + 1'b1;
            case (ph)
              2'd0:    tok.data = 8'hE2;
              2'd1:    tok.data = 8'h80;
              default: tok.data = 8'h95;
            endcase
          end
        end
      end
      F_MARK: begin
        if (!mid_full) begin
          tok_wr       = 1'b1;
          tok.fin      = 1'b1;
          tok.mark     = 1'b1;
          inmk_next    = 1'b0;
          spc_next     = 1'b0;
          tstart_next  = 1'b0;
          endnl_next   = 1'b0;
          tcnt_next    = '0;
          tclosed_next = 1'b0;
          st_next      = F_IDLE;
        end
      end
      default: st_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= F_IDLE;
      inmk    <= 1'b0;
      spc     <= 1'b0;
      tstart  <= 1'b0;
      endnl   <= 1'b0;
      tcnt    <= '0;
      tclosed <= 1'b0;
      fin_s   <= 1'b0;
    end else begin
      st      <= st_next;
      inmk    <= inmk_next;
      spc     <= spc_next;
      tstart  <= tstart_next;
      endnl   <= endnl_next;
      tcnt    <= tcnt_next;
      tclosed <= tclosed_next;
      fin_s   <= fin_s_next;
    end
  end

  always_ff @(posedge clk) begin
    hk <= hk_next;
    ph <= ph_next;
    if (tag_wr) begin
      tagb[tcnt[TAG_AW-1:0]] <= lc;
    end
  end

endmodule

[hdl/h2t_back.sv]
// Entity decoder with replay of unmatched entity text and document-end handling.
module h2t_back
  import h2t_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  tok_t              tok,
  input  logic              mid_empty,
  output logic              mid_rd,
  output logic              out_wr,
  output res_t              res,
  input  logic              out_full
);

  back_state_t     st, st_next;
  logic [7:0]      win [ENTITY_SPAN];
  logic [SPAN_W-1:0] fill, fill_next;
  logic            eopen, eopen_next;
  logic [7:0]      rep [REPLAY_DEPTH];
  logic [REP_W-1:0] rcnt, rcnt_next;
  logic [SPAN_W-1:0] pidx, pidx_next;
  logic            fin_step, fin_step_next;
  logic [7:0]      hold, hold_next;
  logic            holdv, holdv_next;
  parse_reg_t      ps, ps_next, ps_step;
  logic            win_wr;
  logic [SPAN_W-1:0] win_wi;
  logic [7:0]      win_wd;
  logic            rep_pop, rep_push;
  logic [7:0]      rep_pb;
  logic            have, from_rep, emit, fin_eff;
  logic [7:0]      c, ebyte;
  logic [SPAN_W-1:0] n;
  logic            dec_ok;
  logic [7:0]      dec_byte;
  logic            numeric;

  function automatic parse_reg_t dig_step(input parse_reg_t p, input logic [7:0] ch);
    parse_reg_t  r;
    logic [4:0]  d;
    logic        ok;
    logic [11:0] w;
    r  = p;
    d  = '0;
    ok = 1'b0;
    w  = '0;
    if (ch >= "0" && ch <= "9") begin
      d  = 5'(ch - "0");
      ok = 1'b1;
    end else if (p.hexb && ch >= "a" && ch <= "f") begin
      d  = 5'(ch - "a" + 8'd10);
      ok = 1'b1;
    end else if (p.hexb && ch >= "A" && ch <= "F") begin
      d  = 5'(ch - "A" + 8'd10);
      ok = 1'b1;
    end
    if (ok) begin
      if (p.hexb) begin
        w = {p.val, 4'b0000} + 12'(d);
      end else begin
        w = {1'b0, p.val, 3'b000} + {3'b000, p.val, 1'b0} + 12'(d);
      end
      r.val = (w > 12'd128) ? 8'd128 : w[7:0];
      r.st  = P_DIG;
    end else begin
      r.st = P_STOP;
    end
    return r;
  endfunction

  function automatic parse_reg_t first_step(input parse_reg_t p, input logic [7:0] ch);
    parse_reg_t r;
    r = p;
    if (p.hexb && ch == "0") begin
      r.st  = P_ZERO;
      r.val = '0;
    end else begin
      r = dig_step(p, ch);
    end
    return r;
  endfunction

  function automatic parse_reg_t ws_step(input parse_reg_t p, input logic [7:0] ch);
    parse_reg_t r;
    r = p;
    if (is_ws(ch)) begin
      r.st = P_WS;
    end else if (ch == "+" || ch == "-") begin
      r.neg = (ch == "-");
      r.st  = P_SIGN;
    end else begin
      r = first_step(p, ch);
    end
    return r;
  endfunction

  function automatic parse_reg_t parse_step(input parse_reg_t p, input logic [7:0] ch);
    parse_reg_t r;
    r = p;
    case (p.st)
      P_NM0:  r.st = (ch == "#") ? P_HASH : P_OFF;
      P_HASH: begin
        if (ch == "x" || ch == "X") begin
          r.hexb = 1'b1;
          r.st   = P_WS;
        end else begin
          r.hexb = 1'b0;
          r      = ws_step(r, ch);
        end
      end
      P_WS:   r = ws_step(p, ch);
      P_SIGN: r = first_step(p, ch);
      P_ZERO: begin
        if (ch == "x" || ch == "X") begin
          r.st = P_DIG;
        end else begin
          r = dig_step(p, ch);
        end
      end
      P_DIG:  r = dig_step(p, ch);
      default: r = p;
    endcase
    return r;
  endfunction

  // Decode the name held in the window: numeric or one of six known names.
  always_comb begin
    n        = fill - 1'b1;
    numeric  = (ps.st != P_NM0) && (ps.st != P_OFF);
    dec_ok   = 1'b1;
    dec_byte = CH_QMARK;
    if (numeric) begin
      dec_byte = (!ps.neg && ps.val >= 8'd1 && ps.val <= 8'd127) ? ps.val : CH_QMARK;
    end else if (n == SPAN_W'(3) && win[1] == "a" && win[2] == "m" && win[3] == "p") begin
      dec_byte = "&";
    end else if (n == SPAN_W'(2) && win[1] == "l" && win[2] == "t") begin
      dec_byte = "<";
    end else if (n == SPAN_W'(2) && win[1] == "g" && win[2] == "t") begin
      dec_byte = ">";
    end else if (n == SPAN_W'(4) && win[1] == "q" && win[2] == "u" && win[3] == "o" &&
                 win[4] == "t") begin
      dec_byte = 8'h22;
    end else if (n == SPAN_W'(4) && win[1] == "a" && win[2] == "p" && win[3] == "o" &&
                 win[4] == "s") begin
      dec_byte = 8'h27;
    end else if (n == SPAN_W'(4) && win[1] == "n" && win[2] == "b" && win[3] == "s" &&
                 win[4] == "p") begin
      dec_byte = CH_SPACE;
    end else begin
      dec_ok = 1'b0;
    end
  end

  always_comb begin
    c             = rep[0];
    if (rcnt == '0) begin
      c = tok.data;
    end
    ps_step       = parse_step(ps, c);
    st_next       = st;
    fill_next     = fill;
    eopen_next    = eopen;
    pidx_next     = pidx;
    fin_step_next = fin_step;
    hold_next     = hold;
    holdv_next    = holdv;
    ps_next       = ps;
    win_wr        = 1'b0;
    win_wi        = fill;
    win_wd        = c;
    rep_pop       = 1'b0;
    rep_push      = 1'b0;
    rep_pb        = c;
    mid_rd        = 1'b0;
    emit          = 1'b0;
    ebyte         = c;
    fin_eff       = fin_step;
    out_wr        = 1'b0;
    res           = '{data: 8'h00, none: 1'b0, last: 1'b0};
    have          = 1'b0;
    from_rep      = 1'b0;
    case (st)
      B_RUN: begin
        if (!out_full) begin
          if (rcnt != '0) begin
            have     = 1'b1;
            from_rep = 1'b1;
          end else if (!mid_empty) begin
            mid_rd = 1'b1;
            if (tok.mark) begin
              fin_step_next = 1'b1;
              pidx_next     = '0;
              st_next       = B_FLUSH;
            end else begin
              have          = 1'b1;
              fin_eff       = fin_step | tok.fin;
              fin_step_next = fin_eff;
            end
          end
          if (have) begin
            rep_pop = from_rep;
            if (!eopen) begin
              if (c == CH_AMP) begin
                eopen_next = 1'b1;
                win_wr     = 1'b1;
                win_wi     = '0;
                fill_next  = SPAN_W'(1);
                ps_next    = '{st: P_NM0, hexb: 1'b0, neg: 1'b0, val: 8'h00};
              end else begin
                emit = 1'b1;
              end
            end else if (c == CH_SEMI && dec_ok) begin
              emit       = 1'b1;
              ebyte      = dec_byte;
              eopen_next = 1'b0;
              fill_next  = '0;
            end else if (c != CH_SEMI && fill < SPAN_W'(ENTITY_SPAN)) begin
              win_wr    = 1'b1;
              fill_next = fill + 1'b1;
              ps_next   = ps_step;
            end else begin
              // No match: pass '&' and replay the rest of the window, then this byte.
              emit       = 1'b1;
              ebyte      = CH_AMP;
              eopen_next = 1'b0;
              fill_next  = '0;
              rep_pop    = 1'b0;
              rep_push   = !from_rep;
              if (fill > SPAN_W'(1)) begin
                pidx_next = fill - 1'b1;
                st_next   = B_PUSH;
              end
            end
          end
        end
      end
      B_PUSH: begin
        rep_push  = 1'b1;
        rep_pb    = win[pidx[WIN_AW-1:0]];
        pidx_next = pidx - 1'b1;
        if (pidx == SPAN_W'(1)) begin
          st_next = B_RUN;
        end
      end
      B_FLUSH: begin
        if (!out_full) begin
          if (eopen && pidx < fill) begin
            emit      = 1'b1;
            ebyte     = win[pidx[WIN_AW-1:0]];
            pidx_next = pidx + 1'b1;
          end else begin
            st_next = B_FIN;
          end
        end
      end
      B_FIN: begin
        if (!out_full) begin
          out_wr        = 1'b1;
          if (holdv) begin
            res = '{data: hold, none: 1'b0, last: 1'b1};
          end else begin
            res = '{data: 8'h00, none: 1'b1, last: 1'b1};
          end
          holdv_next    = 1'b0;
          fin_step_next = 1'b0;
          eopen_next    = 1'b0;
          fill_next     = '0;
          st_next       = B_RUN;
        end
      end
      default: st_next = B_RUN;
    endcase
    // Within the last document step hold back one byte so it can carry the end flag.
    if (emit) begin
      if (fin_eff) begin
        hold_next  = ebyte;
        holdv_next = 1'b1;
        if (holdv) begin
          out_wr = 1'b1;
          res    = '{data: hold, none: 1'b0, last: 1'b0};
        end
      end else begin
        out_wr = 1'b1;
        res    = '{data: ebyte, none: 1'b0, last: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= B_RUN;
      fill     <= '0;
      eopen    <= 1'b0;
      rcnt     <= '0;
      pidx     <= '0;
      fin_step <= 1'b0;
      holdv    <= 1'b0;
    end else begin
      st       <= st_next;
      fill     <= fill_next;
      eopen    <= eopen_next;
      pidx     <= pidx_next;
      fin_step <= fin_step_next;
      holdv    <= holdv_next;
      if (rep_push) begin
        rcnt <= (rcnt == REP_W'(REPLAY_DEPTH)) ? rcnt : rcnt + 1'b1;
      end else if (rep_pop) begin
        rcnt <= rcnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    hold <= hold_next;
    ps   <= ps_next;
    if (win_wr) begin
      win[win_wi[WIN_AW-1:0]] <= win_wd;
    end
    if (rep_push) begin
      rep[0] <= rep_pb;
      for (int i = 1; i < REPLAY_DEPTH; i++) begin
        rep[i] <= rep[i-1];
      end
    end else if (rep_pop) begin
      for (int i = 0; i < REPLAY_DEPTH - 1; i++) begin
        rep[i] <= rep[i+1];
      end
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= SPAN_W'(ENTITY_SPAN))
    else $error("entity window overfilled");
  a_replay_range: assert property (@(posedge clk) disable iff (rst)
    rcnt <= REP_W'(REPLAY_DEPTH))
    else $error("replay count out of range");
  a_push_index: assert property (@(posedge clk) disable iff (rst)
    st == B_PUSH |-> (pidx >= SPAN_W'(1) && pidx < SPAN_W'(ENTITY_SPAN)))
    else $error("replay index out of window");
  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    (st == B_FIN && !out_full) |=> (!holdv && !eopen && !fin_step))
    else $error("document end left state behind");

endmodule
